FILE: rtl/edf_rms_priority_ranker_top_macros.svh
// assertion macros for the priority ranker checker
`ifndef EDF_RMS_PRIORITY_RANKER_TOP_MACROS_SVH
`define EDF_RMS_PRIORITY_RANKER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define EPR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("priority ranker check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define EPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("priority ranker check failed");

`endif

FILE: rtl/epr_pkg.sv
// shared types, constants and reset values of the priority ranker
`default_nettype none
package epr_pkg;

  localparam int unsigned DEF_TASKS       = 4;
  localparam int unsigned DEF_TICK_BITS   = 32;
  localparam int unsigned PERIOD_W        = 32;
  localparam int unsigned PRIO_W          = 5;
  localparam int unsigned NUM_PERIOD_REGS = 4;
  localparam int unsigned CFG_IDX_W       = 3;

  // register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0 = 3'd2;

  // policy codes
  localparam logic POLICY_EDF = 1'b0;
  localparam logic POLICY_RMS = 1'b1;

  localparam logic              POLICY_RESET = POLICY_RMS;
  localparam logic [PRIO_W-1:0] TOP_RESET    = 5'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RANK,
    ST_EMIT
  } state_e;

  // control of the cell row
  typedef struct packed {
    logic load;  // latch own key, start a new ring pass
    logic step;  // shift keys one cell along, compare
  } cell_ctrl_t;

  function automatic logic [PERIOD_W-1:0] period_reset(input int unsigned idx);
    logic [PERIOD_W-1:0] val;
    case (idx)
      0:       val = 32'd200;
      1:       val = 32'd1000;
      2:       val = 32'd1000;
      3:       val = 32'd100;
      default: val = 32'd1000;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/epr_if.sv
// handshake interfaces: event input, priority output, configuration write
`default_nettype none
interface epr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  task_req;
  logic [31:0] release_req;

  modport source (output valid, kind, task_req, release_req, input ready);
  modport sink   (input valid, kind, task_req, release_req, output ready);
endinterface

interface epr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] task_slot;
  logic [4:0] priority_res;
  logic       last;

  modport source (output valid, task_slot, priority_res, last, input ready);
  modport sink   (input valid, task_slot, priority_res, last, output ready);
endinterface

interface epr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/epr_cell.sv
// one ring cell: holds a task's release time, key and rank counter
`default_nettype none
module epr_cell import epr_pkg::*; #(
  parameter int unsigned TASKS     = DEF_TASKS,
  parameter int unsigned TICK_BITS = DEF_TICK_BITS,
  parameter int unsigned IDX       = 0,
  localparam int unsigned IDX_W    = $clog2(TASKS),
  localparam int unsigned KEY_W    = (TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic                 wr_en_i,
  input  wire logic [TICK_BITS-1:0] wr_rel_i,
  input  wire logic                 policy_i,
  input  wire logic [PERIOD_W-1:0]  period_i,
  input  wire logic [KEY_W-1:0]     pass_key_i,
  input  wire logic [IDX_W-1:0]     pass_idx_i,
  output logic      [KEY_W-1:0]     pass_key_o,
  output logic      [IDX_W-1:0]     pass_idx_o,
  output logic      [IDX_W-1:0]     rank_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [TICK_BITS-1:0] release_q;
  logic [KEY_W-1:0]     own_key_q, pass_key_q;
  logic [IDX_W-1:0]     pass_idx_q, rank_q;
  logic [TICK_BITS-1:0] deadline;
  logic [KEY_W-1:0]     key_d;
  logic                 beats;

  // deadline wraps at the tick width
  assign deadline = release_q + TICK_BITS'(period_i);
  assign key_d    = (policy_i == POLICY_EDF) ? KEY_W'(deadline) : KEY_W'(period_i);

  // incoming task ranks ahead of this one
  assign beats = (pass_key_i < own_key_q) ||
                 ((pass_key_i == own_key_q) && (pass_idx_i < MY_IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_q <= '0;
      rank_q    <= '0;
    end else begin
      if (wr_en_i) begin
        release_q <= wr_rel_i;
      end
      if (ctrl_i.load) begin
        rank_q <= '0;
      end else if (ctrl_i.step && beats) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      own_key_q  <= key_d;
      pass_key_q <= key_d;
      pass_idx_q <= MY_IDX;
    end else if (ctrl_i.step) begin
      pass_key_q <= pass_key_i;
      pass_idx_q <= pass_idx_i;
    end
  end

  assign pass_key_o = pass_key_q;
  assign pass_idx_o = pass_idx_q;
  assign rank_o     = rank_q;

endmodule
`default_nettype wire

FILE: rtl/edf_rms_priority_ranker_top.sv
// top level of the edf / rms priority ranker
// Ranks TASKS periodic tasks and emits one priority per task. An item of kind 0
// only records the release time of task_req and gives no result. An item of
// kind 1 records the release time and then re-ranks: first it forms every task's
// key (deadline = release + period wrapping at TICK_BITS under edf, the period
// alone under rms), then the keys travel once around the ring of cells, each
// cell counting the keys that beat its own (smaller key, or equal key from a
// lower task index), then TASKS result items leave in task order, one per cycle
// while the sink is ready, priority = top_priority - rank saturating at zero,
// last set on the final task. A new item is taken only once the last result
// has gone. The user must write configuration through its own channel only
// while the block is idle; the block itself does not enforce it.
`default_nettype none
module edf_rms_priority_ranker_top import epr_pkg::*; #(
  parameter int unsigned TASKS     = DEF_TASKS,
  parameter int unsigned TICK_BITS = DEF_TICK_BITS
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  epr_in_if.sink     in_ch_i,
  epr_out_if.source  out_ch_o,
  epr_cfg_if.sink    cfg_ch_i
);

  localparam int unsigned IDX_W = $clog2(TASKS);
  localparam int unsigned KEY_W = (TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASKS - 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TASKS - 2);

  // configuration registers
  logic                policy_q;
  logic [PRIO_W-1:0]   top_q;
  logic [PERIOD_W-1:0] period_q [TASKS];
  logic                cfg_fire;

  assign cfg_ch_i.ready = 1'b1;
  assign cfg_fire       = cfg_ch_i.valid && cfg_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RESET;
      top_q    <= TOP_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_ch_i.index)
        CFG_POLICY: policy_q <= cfg_ch_i.data[0];
        CFG_TOP:    top_q    <= cfg_ch_i.data[PRIO_W-1:0];
        default:    ;
      endcase
    end
  end

  // one period register per task; tasks past the register list keep their reset
  for (genvar i = 0; i < TASKS; i++) begin : g_period
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        period_q[i] <= period_reset(i);
      end else if (cfg_fire && (i < NUM_PERIOD_REGS) &&
                   (cfg_ch_i.index == CFG_IDX_W'(CFG_PERIOD0 + i))) begin
        period_q[i] <= cfg_ch_i.data;
      end
    end
  end

  // sequencer
  state_e           state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             in_fire, out_fire;
  cell_ctrl_t       ctrl;

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;
  assign out_fire      = out_ch_o.valid && out_ch_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      slot_q  <= slot_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    slot_d    = slot_q;
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // release time is stored at the accept edge itself
        if (in_fire && in_ch_i.kind) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctrl.load = 1'b1;
        step_d    = '0;
        state_d   = ST_RANK;
      end
      ST_RANK: begin
        ctrl.step = 1'b1;
        step_d    = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          slot_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          slot_d = slot_q + 1'b1;
          if (slot_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ring of cells, keys move from cell i-1 to cell i
  logic [KEY_W-1:0] pass_key [TASKS];
  logic [IDX_W-1:0] pass_idx [TASKS];
  logic [IDX_W-1:0] rank     [TASKS];
  logic [TICK_BITS-1:0] wr_rel;

  assign wr_rel = TICK_BITS'(in_ch_i.release_req);

  for (genvar i = 0; i < TASKS; i++) begin : g_cell
    localparam int unsigned PREV = (i + TASKS - 1) % TASKS;
    logic wr_en;

    // task indexes the request field cannot reach are never written
    assign wr_en = in_fire && (32'(in_ch_i.task_req) == 32'(i));

    epr_cell #(
      .TASKS     (TASKS),
      .TICK_BITS (TICK_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_en_i    (wr_en),
      .wr_rel_i   (wr_rel),
      .policy_i   (policy_q),
      .period_i   (period_q[i]),
      .pass_key_i (pass_key[PREV]),
      .pass_idx_i (pass_idx[PREV]),
      .pass_key_o (pass_key[i]),
      .pass_idx_o (pass_idx[i]),
      .rank_o     (rank[i])
    );
  end

  // result item for the task under slot_q
  logic [PRIO_W-1:0] slot_rank;

  assign slot_rank = PRIO_W'(rank[slot_q]);

  assign out_ch_o.valid        = (state_q == ST_EMIT);
  assign out_ch_o.task_slot    = 2'(slot_q);
  assign out_ch_o.priority_res = (top_q >= slot_rank) ? (top_q - slot_rank) : '0;
  assign out_ch_o.last         = (slot_q == LAST_IDX);

endmodule
`default_nettype wire

FILE: rtl/epr_checker.sv
// port-level checks of the priority ranker, bound to the top level
`default_nettype none
`include "edf_rms_priority_ranker_top_macros.svh"
module epr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       in_kind_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] out_task_slot_i,
  input wire logic       out_last_i
);

  // input is never taken while results are pending
  `EPR_ASSERT_IMPL(a_busy_emit, out_valid_i, !in_ready_i)

  // a kind 0 item gives no result
  `EPR_ASSERT_NEXT(a_kind0_quiet, in_valid_i && in_ready_i && !in_kind_i, !out_valid_i)

  // results of one burst follow without a gap
  `EPR_ASSERT_NEXT(a_burst_cont, out_valid_i && out_ready_i && !out_last_i, out_valid_i)

  // task slots count up within a burst
  `EPR_ASSERT_NEXT(a_slot_incr, out_valid_i && out_ready_i && !out_last_i,
                   out_task_slot_i == 2'($past(out_task_slot_i) + 2'd1))

endmodule

bind edf_rms_priority_ranker_top epr_checker u_epr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch_i.valid),
  .in_ready_i      (in_ch_i.ready),
  .in_kind_i       (in_ch_i.kind),
  .out_valid_i     (out_ch_o.valid),
  .out_ready_i     (out_ch_o.ready),
  .out_task_slot_i (out_ch_o.task_slot),
  .out_last_i      (out_ch_o.last)
);
`default_nettype wire
